@@ src/hcbd_pkg.sv @@
// Shared types and character constants for the chunked body decoder.
package hcbd_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_last;
   } item_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] payload_byte;
      logic       end_of_body;
      logic       truncated;
   } result_type;

endpackage

@@ src/hcbd_parser.sv @@
// Chunk framing parser: phase state, size accumulator and data byte counter.
module hcbd_parser #(
   parameter int SIZE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 chunked_mode,
   input  hcbd_pkg::item_type   item,
   output logic                 result_valid,
   output hcbd_pkg::result_type result
);
   import hcbd_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_EXT,
      PH_LF,
      PH_DATA,
      PH_TR1,
      PH_TR2,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0] size_acc_ff, size_acc_in;
   logic [SIZE_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [SIZE_WIDTH-1:0] left_dec;
   logic [SIZE_WIDTH-1:0] digit_ext;
   logic                  is_hex, is_white, size_end, overflow;
   logic [3:0]            digit;
   logic                  has, eob, trunc;
   logic [7:0]            b;

   assign b = item.body_byte;

   always_comb begin
      is_hex = 1'b1;
      digit  = b[3:0];
      case (b) inside
         [CHAR_0:CHAR_9]:       digit = b[3:0];
         [CHAR_UC_A:CHAR_UC_F],
         [CHAR_LC_A:CHAR_LC_F]: digit = b[3:0] + 4'd9;
         default:               is_hex = 1'b0;
      endcase
      case (b) inside
         [CHAR_TAB:CHAR_CR], CHAR_SPACE: is_white = 1'b1;
         default:                        is_white = 1'b0;
      endcase
   end

   assign digit_ext = {{(SIZE_WIDTH-4){1'b0}}, digit};
   assign overflow  = size_acc_ff[SIZE_WIDTH-1 -: 4] != 4'd0;
   assign left_dec  = (bytes_left_ff != '0)
                      ? bytes_left_ff - {{(SIZE_WIDTH-1){1'b0}}, 1'b1} : bytes_left_ff;

   always_comb begin
      phase_in      = phase_ff;
      size_acc_in   = size_acc_ff;
      bytes_left_in = bytes_left_ff;
      has           = 1'b0;
      eob           = 1'b0;
      trunc         = 1'b0;
      size_end      = 1'b0;
      if (!chunked_mode) begin
         has = 1'b1;
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               if (is_hex) begin
                  size_acc_in = digit_ext;
                  phase_in    = PH_DIGITS;
               end else if (!is_white) begin
                  size_end = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (is_hex) begin
                  // saturate once the top nibble is occupied
                  size_acc_in = overflow ? '1 : {size_acc_ff[SIZE_WIDTH-5:0], digit};
               end else begin
                  size_end = 1'b1;
               end
            end
            PH_EXT: begin
               if (b == CHAR_CR) begin
                  phase_in = PH_LF;
               end
            end
            PH_LF: begin
               bytes_left_in = size_acc_ff;
               phase_in      = PH_DATA;
            end
            PH_DATA: begin
               has           = 1'b1;
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_TR1;
               end
            end
            PH_TR1: phase_in = PH_TR2;
            PH_TR2: begin
               size_acc_in = '0;
               phase_in    = PH_LEAD;
            end
            default: ;
         endcase
         // no digits, or a zero size, terminates the body
         if (size_end) begin
            if (phase_ff == PH_LEAD || size_acc_ff == '0) begin
               phase_in = PH_DONE;
               eob      = 1'b1;
            end else begin
               phase_in = (b == CHAR_CR) ? PH_LF : PH_EXT;
            end
         end
         if (item.body_last) begin
            trunc = phase_in != PH_DONE;
         end
      end
      if (item.body_last) begin
         eob           = 1'b1;
         phase_in      = PH_LEAD;
         size_acc_in   = '0;
         bytes_left_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEAD;
         size_acc_ff   <= '0;
         bytes_left_ff <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         size_acc_ff   <= size_acc_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   assign result_valid        = has | eob;
   assign result.has_byte     = has;
   assign result.payload_byte = has ? b : 8'd0;
   assign result.end_of_body  = eob;
   assign result.truncated    = trunc;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item.body_last |=> phase_ff == PH_LEAD && size_acc_ff == '0)
      else $error("parser not cleared after last item");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> bytes_left_ff != '0)
      else $error("data phase with empty byte count");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      step_en && chunked_mode && phase_ff == PH_DONE && !item.body_last |-> !result_valid)
      else $error("result after terminator");

   a_trunc_eob: assert property (@(posedge clock) disable iff (reset)
      result.truncated |-> result.end_of_body && item.body_last)
      else $error("truncation flagged off the last item");

endmodule

@@ src/http_chunked_body_decoder.sv @@
// HTTP chunked body decoder: input register, parser and result register.
//
// Usage: body bytes enter on the req_ channel (valid/ready), one per item,
// with req_body_last marking the final byte of a body. Each item gives zero
// or one result on the rsp_ channel: a payload byte, an end-of-body marker,
// or both. Framing bytes (size, extension, CR/LF, trailers) give no result.
// csr_wr_en/csr_wr_data set chunked_mode (reset 1); with 0 every byte passes
// through. Write it only while no item is in flight.
//
// An accepted item is held in the input register, and its result is then
// registered in the result register, which drives rsp_.
// Throughput: one item per cycle while the result register is free; the parse
// step is a single phase update plus a 4-bit shift-add on the size register,
// done between the input register and the result register.
// Reset: synchronous, clears both pipeline valid flags and the parser to the
// start of a size field. A stalled rsp_ready holds the result register; the
// input register then fills and req_ready drops until the result is taken.
module http_chunked_body_decoder #(
   parameter int SIZE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_body_byte,
   input  logic       req_body_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_end_of_body,
   output logic       rsp_truncated,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import hcbd_pkg::*;

   logic       chunked_mode_ff;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       out_free, step_en, req_fire, res_valid;
   result_type res;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step_en);
   assign out_valid_in = step_en ? res_valid : (out_valid_ff && !rsp_ready);

   hcbd_parser #(
      .SIZE_WIDTH(SIZE_WIDTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .chunked_mode (chunked_mode_ff),
      .item         (in_item_ff),
      .result_valid (res_valid),
      .result       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff <= 1'b1;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            chunked_mode_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: input loads on handshake, result on parse step only
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.body_byte <= req_body_byte;
         in_item_ff.body_last <= req_body_last;
      end
      if (step_en) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_has_byte     = out_ff.has_byte;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_end_of_body  = out_ff.end_of_body;
   assign rsp_truncated    = out_ff.truncated;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("held result lost");

   a_no_drop_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending input item lost");

   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid |=> out_valid_ff)
      else $error("result not registered");

endmodule
